FILE: hw/rtl/ledpwm_pkg.sv
package ledpwm_pkg;

  // Effect timer period and PWM phase count
  localparam int unsigned TimerPeriod = 2000;
  localparam int unsigned PwmSteps    = 50;
  localparam int unsigned HalfFlash   = 150;

  localparam int unsigned TimeW  = 11;
  localparam int unsigned PhaseW = 6;
  localparam int unsigned LevelW = 6;
  localparam int unsigned ManW   = 10;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [LevelW-1:0] LevelFull = LevelW'(50);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE_TX    = 3'd0,
    REG_MODE_RX    = 3'd1,
    REG_MODE_ERR   = 3'd2,
    REG_MANUAL_TX  = 3'd3,
    REG_MANUAL_RX  = 3'd4,
    REG_MANUAL_ERR = 3'd5
  } cfg_reg_t;

  // Effect modes
  typedef enum logic [ModeW-1:0] {
    MODE_OFF    = 4'd0,
    MODE_ON     = 4'd1,
    MODE_F10    = 4'd2,
    MODE_F2_5   = 4'd3,
    MODE_F1     = 4'd4,
    MODE_F2     = 4'd5,
    MODE_F3     = 4'd6,
    MODE_SF2_5  = 4'd7,
    MODE_SF1    = 4'd8,
    MODE_SF2    = 4'd9,
    MODE_SF3    = 4'd10,
    MODE_STRB05 = 4'd11,
    MODE_STRB1  = 4'd12,
    MODE_STRB2  = 4'd13,
    MODE_STRB5  = 4'd14,
    MODE_MANUAL = 4'd15
  } mode_t;

  // Timer stage contents handed to the level logic
  typedef struct packed {
    logic [TimeW-1:0]  t;
    logic [PhaseW-1:0] phase;
  } stage_t;

  localparam logic [LevelW-1:0] GAMMA [0:50] = '{
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd3,  6'd4,
    6'd4,  6'd5,  6'd5,  6'd6,  6'd7,  6'd8,  6'd8,  6'd9,  6'd10, 6'd12,
    6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd26,
    6'd28, 6'd30, 6'd32, 6'd35, 6'd37, 6'd39, 6'd42, 6'd44, 6'd47, 6'd50, 6'd50
  };

  // Gamma lookup; a nonzero brightness never gives level 0
  function automatic logic [LevelW-1:0] level_of(logic [5:0] idx, logic nz);
    logic [5:0]        i;
    logic [LevelW-1:0] lv;
    i  = (idx > 6'd50) ? 6'd50 : idx;
    lv = GAMMA[i];
    if (!nz) return '0;
    return (lv == '0) ? LevelW'(1) : lv;
  endfunction

  // Triangle weight 150-|v-c| inside [c-150, c+150)
  function automatic logic [7:0] tri_w(logic [TimeW-1:0] v, logic [TimeW-1:0] c);
    logic signed [11:0] d;
    logic [11:0]        a;
    d = $signed({1'b0, v}) - $signed({1'b0, c});
    a = d[11] ? 12'(-d) : 12'(d);
    if (d < -12'sd150 || d >= 12'sd150) return '0;
    return 8'(12'(HalfFlash) - a);
  endfunction

  // n/3 for n <= 150 by reciprocal multiply
  function automatic logic [5:0] div3(logic [7:0] n);
    logic [15:0] p;
    p = 16'(n) * 16'd171;
    return p[14:9];
  endfunction

  // m/20 for m <= 1000 by reciprocal multiply
  function automatic logic [5:0] div20(logic [ManW-1:0] m);
    logic [17:0] p;
    p = 18'(m) * 18'd205;
    return p[17:12];
  endfunction

endpackage

FILE: hw/rtl/ledpwm_in_if.sv
interface ledpwm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

FILE: hw/rtl/ledpwm_out_if.sv
interface ledpwm_out_if;
  logic       valid;
  logic       ready;
  logic       pin_tx;
  logic       pin_rx;
  logic       pin_err;
  logic [5:0] level_tx;
  logic [5:0] level_rx;
  logic [5:0] level_err;

  modport source (output valid, output pin_tx, output pin_rx, output pin_err,
                  output level_tx, output level_rx, output level_err, input ready);
  modport sink   (input valid, input pin_tx, input pin_rx, input pin_err,
                  input level_tx, input level_rx, input level_err, output ready);
endinterface

FILE: hw/rtl/ledpwm_timer.sv
module ledpwm_timer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [15:0]         elapsed_ms,
  output ledpwm_pkg::stage_t  stage
);
  import ledpwm_pkg::*;

  logic [TimeW-1:0]  t_r, t_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [16:0]       sum;

  // Timer add with reset to zero at the period, phase wraps at 50
  always_comb begin
    sum       = 17'(t_r) + 17'(elapsed_ms);
    t_nxt     = (sum >= 17'(TimerPeriod)) ? '0 : sum[TimeW-1:0];
    phase_nxt = (phase_r == PhaseW'(PwmSteps - 1)) ? '0 : phase_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r     <= '0;
      phase_r <= '0;
    end else if (accept) begin
      t_r     <= t_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign stage.t     = t_r;
  assign stage.phase = phase_r;
endmodule

FILE: hw/rtl/ledpwm_level.sv
module ledpwm_level (
  input  ledpwm_pkg::mode_t              mode,
  input  logic [ledpwm_pkg::ManW-1:0]    manual,
  input  logic [ledpwm_pkg::TimeW-1:0]   t,
  output logic [ledpwm_pkg::LevelW-1:0]  level
);
  import ledpwm_pkg::*;

  logic [8:0]      m400, m500;
  logic [6:0]      m100;
  logic [7:0]      m200;
  logic [9:0]      m1000;
  logic [7:0]      n_sf1, n_first, n_500, n_900, n_sf2, n_sf3;
  logic [ManW-1:0] msat;
  logic            on;

  // Constant remainders by range select (t < 2000)
  always_comb begin
    if      (t >= 11'd1600) m400 = 9'(t - 11'd1600);
    else if (t >= 11'd1200) m400 = 9'(t - 11'd1200);
    else if (t >= 11'd800)  m400 = 9'(t - 11'd800);
    else if (t >= 11'd400)  m400 = 9'(t - 11'd400);
    else                    m400 = 9'(t);

    if      (m400 >= 9'd300) m100 = 7'(m400 - 9'd300);
    else if (m400 >= 9'd200) m100 = 7'(m400 - 9'd200);
    else if (m400 >= 9'd100) m100 = 7'(m400 - 9'd100);
    else                     m100 = 7'(m400);

    m200  = (m400 >= 9'd200) ? 8'(m400 - 9'd200) : 8'(m400);
    m1000 = (t >= 11'd1000) ? 10'(t - 11'd1000) : 10'(t);

    if      (t >= 11'd1500) m500 = 9'(t - 11'd1500);
    else if (t >= 11'd1000) m500 = 9'(t - 11'd1000);
    else if (t >= 11'd500)  m500 = 9'(t - 11'd500);
    else                    m500 = 9'(t);
  end

  // Soft flash weights; the first pulse also covers the end of the period
  always_comb begin
    n_sf1 = tri_w(11'(m400), 11'd100);
    if (t < 11'd250)       n_first = tri_w(t, 11'd100);
    else if (t >= 11'd1950) n_first = 8'(t - 11'd1950);
    else                   n_first = '0;
    n_500 = tri_w(t, 11'd500);
    n_900 = tri_w(t, 11'd900);
    n_sf2 = (n_first != '0) ? n_first : n_500;
    n_sf3 = (n_sf2 != '0) ? n_sf2 : n_900;
    msat  = (manual > ManW'(1000)) ? ManW'(1000) : manual;
  end

  // Mode select
  always_comb begin
    on    = 1'b0;
    level = '0;
    case (mode)
      MODE_OFF:    level = '0;
      MODE_ON:     on = 1'b1;
      MODE_F10:    on = (m100 <= 7'd50);
      MODE_F2_5:   on = (m400 > 9'd50) && (m400 <= 9'd200);
      MODE_F1:     on = (t <= 11'd200);
      MODE_F2:     on = (t < 11'd200) || (t >= 11'd400 && t < 11'd600);
      MODE_F3:     on = (t < 11'd200) || (t >= 11'd400 && t < 11'd600) ||
                        (t >= 11'd800 && t < 11'd1000);
      MODE_SF2_5,
      MODE_SF1:    level = level_of(div3(n_sf1), n_sf1 != '0);
      MODE_SF2:    level = level_of(div3(n_sf2), n_sf2 != '0);
      MODE_SF3:    level = level_of(div3(n_sf3), n_sf3 != '0);
      MODE_STRB05: on = (t <= 11'd2);
      MODE_STRB1:  on = (m1000 <= 10'd2);
      MODE_STRB2:  on = (m500 > 9'd50) && (m500 <= 9'd52);
      MODE_STRB5:  on = (m200 <= 8'd2);
      default:     level = level_of(div20(msat), msat != '0);
    endcase
    if (on) level = LevelFull;
  end
endmodule

FILE: hw/rtl/led_effect_pwm_driver.sv
// Channel   Dir  Payload                                        Handshake
// in_item   in   elapsed_ms[15:0]                               valid/ready
// out_item  out  pin_tx, pin_rx, pin_err, level_tx/rx/err[5:0]  valid/ready
// cfg_*     in   cfg_idx[2:0], cfg_data[9:0]                    cfg_we, no ready
//
// One item per cycle sustained while the output takes items; each item
// passes the timer/phase register, then the level logic into the result register.
// Reset (rst_n low, synchronous) clears timer, phase, modes, manual levels
// and both valid flags.
// A stalled result holds in the output register; the timer stage keeps
// accepting until it also holds an item that cannot move on.
module led_effect_pwm_driver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ledpwm_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [ledpwm_pkg::CfgDataW-1:0]    cfg_data,
  ledpwm_in_if.sink                          in_item,
  ledpwm_out_if.source                       out_item
);
  import ledpwm_pkg::*;

  mode_t           mode_r [3];
  logic [ManW-1:0] manual_r [3];
  logic            v1_r, v1_nxt;
  logic            ov_r, ov_nxt;
  logic            adv2, acc;
  stage_t          stage;
  logic [LevelW-1:0] lv [3];
  logic [2:0]        pin_r;
  logic [LevelW-1:0] level_r [3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mode_r[i]   <= MODE_OFF;
        manual_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MODE_TX:    mode_r[0]   <= mode_t'(cfg_data[ModeW-1:0]);
        REG_MODE_RX:    mode_r[1]   <= mode_t'(cfg_data[ModeW-1:0]);
        REG_MODE_ERR:   mode_r[2]   <= mode_t'(cfg_data[ModeW-1:0]);
        REG_MANUAL_TX:  manual_r[0] <= cfg_data;
        REG_MANUAL_RX:  manual_r[1] <= cfg_data;
        REG_MANUAL_ERR: manual_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign adv2          = !ov_r || out_item.ready;
  assign in_item.ready = !v1_r || adv2;
  assign acc           = in_item.valid && in_item.ready;

  always_comb begin
    v1_nxt = acc ? 1'b1 : (adv2 ? 1'b0 : v1_r);
    ov_nxt = adv2 ? v1_r : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      ov_r <= ov_nxt;
    end
  end

  ledpwm_timer u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (acc),
    .elapsed_ms (in_item.elapsed_ms),
    .stage      (stage)
  );

  for (genvar g = 0; g < 3; g++) begin : g_led
    ledpwm_level u_level (
      .mode   (mode_r[g]),
      .manual (manual_r[g]),
      .t      (stage.t),
      .level  (lv[g])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      for (int i = 0; i < 3; i++) begin
        pin_r[i]   <= (stage.phase < lv[i]);
        level_r[i] <= lv[i];
      end
    end
  end

  assign out_item.valid     = ov_r;
  assign out_item.pin_tx    = pin_r[0];
  assign out_item.pin_rx    = pin_r[1];
  assign out_item.pin_err   = pin_r[2];
  assign out_item.level_tx  = level_r[0];
  assign out_item.level_rx  = level_r[1];
  assign out_item.level_err = level_r[2];

  // Checks
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage.phase < PhaseW'(PwmSteps)) else $error("pwm phase out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage.t < TimeW'(TimerPeriod)) else $error("effect timer out of range");

  a_pin_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (pin_r[0] || pin_r[1] || pin_r[2]) |->
      ((!pin_r[0] || level_r[0] != '0) && (!pin_r[1] || level_r[1] != '0) &&
       (!pin_r[2] || level_r[2] != '0)))
    else $error("pin driven with zero level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (level_r[0] <= LevelFull && level_r[1] <= LevelFull &&
              level_r[2] <= LevelFull))
    else $error("level above full scale");
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ledpwm_pkg::*;

  // Result item as seen on the output channel
  typedef struct packed {
    logic       pin_tx;
    logic       pin_rx;
    logic       pin_err;
    logic [5:0] level_tx;
    logic [5:0] level_rx;
    logic [5:0] level_err;
  } led_result_t;

  // One row of the directed table: a register write or a tick
  typedef struct {
    bit          is_cfg;
    cfg_reg_t    addr;
    logic [9:0]  data;
    logic [15:0] ms;
    bit          typed;
    led_result_t res;
  } stim_row_t;

  localparam logic [5:0] BRIGHT_CURVE [51] = '{
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd3,  6'd4,
    6'd4,  6'd5,  6'd5,  6'd6,  6'd7,  6'd8,  6'd8,  6'd9,  6'd10, 6'd12,
    6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd26,
    6'd28, 6'd30, 6'd32, 6'd35, 6'd37, 6'd39, 6'd42, 6'd44, 6'd47, 6'd50, 6'd50
  };

  localparam led_result_t ALL_DARK = '0;
  localparam led_result_t TX_ERR_FULL = '{pin_tx: 1'b1, pin_rx: 1'b0, pin_err: 1'b1,
                                          level_tx: 6'd50, level_rx: 6'd0,
                                          level_err: 6'd50};

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [9:0] cfg_data;

  ledpwm_in_if  in_item ();
  ledpwm_out_if out_item ();

  led_effect_pwm_driver uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // Shadow of the block's state and registers
  logic [10:0] eff_time;
  logic [5:0]  pwm_ph;
  mode_t       mode_shadow [3];
  logic [9:0]  led_manual [3];

  led_result_t expected_q [$];
  stim_row_t   stim_table [$];
  int          fail_count;
  int          in_idle_pct;
  int          out_idle_pct;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Gamma lookup with the nonzero floor
  function automatic logic [5:0] lit_level(int idx, bit nz);
    logic [5:0] lv;
    if (!nz) return 6'd0;
    if (idx > 50) idx = 50;
    lv = BRIGHT_CURVE[idx];
    return (lv == 6'd0) ? 6'd1 : lv;
  endfunction

  // Triangle of half width 150 around c, zero outside [c-150, c+150)
  function automatic int flash_weight(int v, int c);
    int d;
    d = v - c;
    if (d < -150 || d >= 150) return 0;
    if (d < 0) d = -d;
    return 150 - d;
  endfunction

  // Pulse centred at 100, seen across the wrap of the 2000 ms timer
  function automatic int first_flash(int t);
    if (t < 250) return flash_weight(t, 100);
    if (t >= 1950) return flash_weight(t, 2100);
    return 0;
  endfunction

  function automatic logic [5:0] effect_level(mode_t m, logic [9:0] man, int t);
    int n;
    int mv;
    bit lit;
    lit = 1'b0;
    case (m)
      MODE_OFF:    return 6'd0;
      MODE_ON:     lit = 1'b1;
      MODE_F10:    lit = (t % 100) <= 50;
      MODE_F2_5:   lit = (t % 400) > 50 && (t % 400) <= 200;
      MODE_F1:     lit = t <= 200;
      MODE_F2:     lit = t < 200 || (t >= 400 && t < 600);
      MODE_F3:     lit = t < 200 || (t >= 400 && t < 600) || (t >= 800 && t < 1000);
      MODE_SF2_5, MODE_SF1: begin
        n = flash_weight(t % 400, 100);
        return lit_level(n / 3, n != 0);
      end
      MODE_SF2: begin
        n = first_flash(t);
        if (n == 0) n = flash_weight(t, 500);
        return lit_level(n / 3, n != 0);
      end
      MODE_SF3: begin
        n = first_flash(t);
        if (n == 0) n = flash_weight(t, 500);
        if (n == 0) n = flash_weight(t, 900);
        return lit_level(n / 3, n != 0);
      end
      MODE_STRB05: lit = t <= 2;
      MODE_STRB1:  lit = (t % 1000) <= 2;
      MODE_STRB2:  lit = (t % 500) > 50 && (t % 500) <= 52;
      MODE_STRB5:  lit = (t % 200) <= 2;
      MODE_MANUAL: begin
        mv = (man > 10'd1000) ? 1000 : int'(man);
        return lit_level(mv / 20, mv != 0);
      end
      default:     return 6'd0;
    endcase
    return lit ? lit_level(50, 1'b1) : 6'd0;
  endfunction

  // Advance timer and phase by one tick, return the pins and levels
  function automatic led_result_t advance_leds(logic [15:0] ms);
    int unsigned sum;
    logic [5:0]  lv [3];
    led_result_t r;
    sum = int'(eff_time) + int'(ms);
    eff_time = (sum >= 2000) ? 11'd0 : 11'(sum);
    pwm_ph = (pwm_ph + 6'd1 >= 6'd50) ? 6'd0 : pwm_ph + 6'd1;
    for (int i = 0; i < 3; i++) lv[i] = effect_level(mode_shadow[i], led_manual[i], eff_time);
    r.level_tx  = lv[0];
    r.level_rx  = lv[1];
    r.level_err = lv[2];
    r.pin_tx    = pwm_ph < lv[0];
    r.pin_rx    = pwm_ph < lv[1];
    r.pin_err   = pwm_ph < lv[2];
    return r;
  endfunction

  function automatic void check_field(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Register write; cfg_we is lowered by whoever drives next
  task automatic write_reg(cfg_reg_t a, logic [9:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= a;
    cfg_data <= d;
    @(posedge clk);
    case (a)
      REG_MODE_TX:    mode_shadow[0] = mode_t'(d[3:0]);
      REG_MODE_RX:    mode_shadow[1] = mode_t'(d[3:0]);
      REG_MODE_ERR:   mode_shadow[2] = mode_t'(d[3:0]);
      REG_MANUAL_TX:  led_manual[0] = d;
      REG_MANUAL_RX:  led_manual[1] = d;
      REG_MANUAL_ERR: led_manual[2] = d;
      default: ;
    endcase
  endtask

  // Send one tick item, then queue its expected result
  task automatic send_tick(logic [15:0] ms, bit typed, led_result_t typed_res);
    led_result_t predicted;
    cfg_we <= 1'b0;
    if ($urandom_range(99) < in_idle_pct) begin
      in_item.valid      <= 1'b0;
      in_item.elapsed_ms <= 16'($urandom);
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_item.valid      <= 1'b1;
    in_item.elapsed_ms <= ms;
    do @(posedge clk); while (!(in_item.valid === 1'b1 && in_item.ready === 1'b1));
    predicted = advance_leds(ms);
    expected_q.push_back(typed ? typed_res : predicted);
  endtask

  // Stop sending and let every pending item come out
  task automatic drain_block();
    in_item.valid <= 1'b0;
    cfg_we        <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_cfg(cfg_reg_t a, logic [9:0] d);
    stim_row_t row;
    row = '{is_cfg: 1'b1, addr: a, data: d, ms: 16'd0, typed: 1'b0, res: ALL_DARK};
    stim_table.push_back(row);
  endtask

  task automatic add_modes(mode_t m0, mode_t m1, mode_t m2);
    add_cfg(REG_MODE_TX, 10'(m0));
    add_cfg(REG_MODE_RX, 10'(m1));
    add_cfg(REG_MODE_ERR, 10'(m2));
  endtask

  task automatic add_tick(logic [15:0] ms, bit typed, led_result_t res);
    stim_row_t row;
    row = '{is_cfg: 1'b0, addr: REG_MODE_TX, data: 10'd0, ms: ms, typed: typed, res: res};
    stim_table.push_back(row);
  endtask

  function automatic logic [15:0] random_ms();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 16'($urandom_range(0, 24));
    if (r < 90) return 16'($urandom_range(0, 700));
    return 16'($urandom);
  endfunction

  // Manual level, weighted toward zero, the low floor and saturation
  function automatic logic [9:0] pick_manual();
    case ($urandom_range(9))
      0:       return 10'd0;
      1:       return 10'($urandom_range(1, 19));
      2:       return 10'd1000;
      3:       return 10'($urandom_range(1001, 1023));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_setting();
    write_reg(REG_MODE_TX, 10'($urandom_range(15)));
    write_reg(REG_MODE_RX, 10'($urandom_range(15)));
    write_reg(REG_MODE_ERR, 10'($urandom_range(15)));
    write_reg(REG_MANUAL_TX, pick_manual());
    write_reg(REG_MANUAL_RX, pick_manual());
    write_reg(REG_MANUAL_ERR, pick_manual());
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin : result_check
    led_result_t got;
    led_result_t want;
    if (rst_n && out_item.valid === 1'b1 && out_item.ready === 1'b1) begin
      got = '{pin_tx: out_item.pin_tx, pin_rx: out_item.pin_rx, pin_err: out_item.pin_err,
              level_tx: out_item.level_tx, level_rx: out_item.level_rx,
              level_err: out_item.level_err};
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected item: expected none, got %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        check_field("pin_tx", 6'(want.pin_tx), 6'(got.pin_tx));
        check_field("pin_rx", 6'(want.pin_rx), 6'(got.pin_rx));
        check_field("pin_err", 6'(want.pin_err), 6'(got.pin_err));
        check_field("level_tx", want.level_tx, got.level_tx);
        check_field("level_rx", want.level_rx, got.level_rx);
        check_field("level_err", want.level_err, got.level_err);
      end
    end
    out_item.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    bit need_drain;
    stim_row_t row;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    in_item.valid      = 1'b0;
    in_item.elapsed_ms = '0;
    out_item.ready     = 1'b0;
    fail_count         = 0;
    eff_time           = '0;
    pwm_ph             = '0;
    for (int i = 0; i < 3; i++) begin
      mode_shadow[i] = MODE_OFF;
      led_manual[i]  = '0;
    end
    in_idle_pct  = 32;
    out_idle_pct = 60;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    add_tick(16'd0, 1'b1, ALL_DARK);
    add_modes(MODE_ON, MODE_OFF, MODE_MANUAL);
    add_cfg(REG_MANUAL_TX, 10'd1023);
    add_cfg(REG_MANUAL_RX, 10'd0);
    add_cfg(REG_MANUAL_ERR, 10'd1000);
    add_tick(16'hFFFF, 1'b1, TX_ERR_FULL);
    add_tick(16'd1999, 1'b1, TX_ERR_FULL);
    // saturated manual, and low levels that floor to one
    add_modes(MODE_MANUAL, MODE_MANUAL, MODE_MANUAL);
    add_cfg(REG_MANUAL_RX, 10'd19);
    add_cfg(REG_MANUAL_ERR, 10'd1);
    add_tick(16'd1, 1'b0, ALL_DARK);
    add_tick(16'd19, 1'b0, ALL_DARK);
    // square flashes at their edges
    add_modes(MODE_F10, MODE_F2_5, MODE_F1);
    add_tick(16'd31, 1'b0, ALL_DARK);
    add_tick(16'd1, 1'b0, ALL_DARK);
    add_tick(16'd149, 1'b0, ALL_DARK);
    add_tick(16'd1, 1'b0, ALL_DARK);
    add_modes(MODE_F2, MODE_F3, MODE_SF2_5);
    add_tick(16'd398, 1'b0, ALL_DARK);
    add_tick(16'd201, 1'b0, ALL_DARK);
    add_tick(16'd199, 1'b0, ALL_DARK);
    // soft flashes around the timer wrap and the later centres
    add_modes(MODE_SF1, MODE_SF2, MODE_SF3);
    add_tick(16'd951, 1'b0, ALL_DARK);
    add_tick(16'd49, 1'b0, ALL_DARK);
    add_tick(16'd101, 1'b0, ALL_DARK);
    add_tick(16'd100, 1'b0, ALL_DARK);
    add_tick(16'd400, 1'b0, ALL_DARK);
    add_tick(16'd400, 1'b0, ALL_DARK);
    // strobes
    add_modes(MODE_STRB05, MODE_STRB1, MODE_STRB2);
    add_tick(16'd1100, 1'b0, ALL_DARK);
    add_tick(16'd2, 1'b0, ALL_DARK);
    add_tick(16'd998, 1'b0, ALL_DARK);
    add_tick(16'd51, 1'b0, ALL_DARK);
    add_modes(MODE_STRB5, MODE_OFF, MODE_ON);
    add_tick(16'd149, 1'b0, ALL_DARK);
    add_tick(16'hFFFF, 1'b0, ALL_DARK);

    need_drain = 1'b0;
    foreach (stim_table[k]) begin
      row = stim_table[k];
      if (row.is_cfg) begin
        if (need_drain) drain_block();
        need_drain = 1'b0;
        write_reg(row.addr, row.data);
      end else begin
        send_tick(row.ms, row.typed, row.res);
        need_drain = 1'b1;
      end
    end

    // Random ticks in three idling phases, new settings between chunks
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 60 : 0;
      out_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 32 : 0;
      for (int chunk = 0; chunk < 10; chunk++) begin
        drain_block();
        random_setting();
        repeat (25) send_tick(random_ms(), 1'b0, ALL_DARK);
      end
    end

    drain_block();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
